// File: hw/rtl/bts_pkg.sv
// ---------------------------------------------------------------------------
// Bilinear texture sampler package
// Shared types and fixed constants for the texture sampler core and its
// channel blend pipeline.
// ---------------------------------------------------------------------------
package bts_pkg;

    // Stream payload widths
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 48;

    // Configuration port
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] CFG_RESET_SIDE = 9'd256;

    // Request kinds carried on tuser
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Fraction and channel widths
    localparam int FRAC_W = 16;
    localparam int CH_W   = 8;
    localparam int ROW_W  = 24;  // row blend, Q8.16
    localparam int SUM_W  = 40;  // column blend, Q8.32
    localparam int RES_W  = 16;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_texel;

    typedef struct packed {
        logic ld_row;  // load row blends
        logic ld_col;  // load column blends
        logic ld_out;  // load rounded result
    } t_blend_ctl;

endpackage

// File: hw/rtl/bts_blend.sv
// ---------------------------------------------------------------------------
// Bilinear blend pipeline
// Three register stages per channel: row blends, column blend, rounding
// to Q8.8. Each stage loads under its own enable from the core.
// ---------------------------------------------------------------------------
module bts_blend (
    input  logic                                i_clk,
    input  bts_pkg::t_blend_ctl                 i_ctl,
    input  bts_pkg::t_texel                     i_t00,
    input  bts_pkg::t_texel                     i_t10,
    input  bts_pkg::t_texel                     i_t01,
    input  bts_pkg::t_texel                     i_t11,
    input  logic [bts_pkg::FRAC_W-1:0]          i_fx,
    input  logic [bts_pkg::FRAC_W-1:0]          i_fy,
    output logic [bts_pkg::RES_W-1:0]           o_red,
    output logic [bts_pkg::RES_W-1:0]           o_green,
    output logic [bts_pkg::RES_W-1:0]           o_blue
);

    function automatic logic [bts_pkg::CH_W-1:0] chan(input bts_pkg::t_texel t, input int ch);
        logic [bts_pkg::CH_W-1:0] c;
        case (ch)
            0: begin
                c = t.red;
            end
            1: begin
                c = t.green;
            end
            default: begin
                c = t.blue;
            end
        endcase
        return c;
    endfunction

    // a*(1-f) + b*f, Q8.16
    function automatic logic [bts_pkg::ROW_W-1:0] lerp_row(
        input logic [bts_pkg::CH_W-1:0]   a,
        input logic [bts_pkg::CH_W-1:0]   b,
        input logic [bts_pkg::FRAC_W-1:0] f
    );
        logic [16:0] w;
        logic [24:0] p0;
        logic [24:0] p1;
        w  = 17'h10000 - {1'b0, f};
        p0 = 25'(a) * 25'(w);
        p1 = 25'(b) * 25'(f);
        return bts_pkg::ROW_W'(p0 + p1);
    endfunction

    // a*(1-f) + b*f, Q8.32
    function automatic logic [bts_pkg::SUM_W-1:0] lerp_col(
        input logic [bts_pkg::ROW_W-1:0]  a,
        input logic [bts_pkg::ROW_W-1:0]  b,
        input logic [bts_pkg::FRAC_W-1:0] f
    );
        logic [16:0] w;
        logic [40:0] p0;
        logic [40:0] p1;
        w  = 17'h10000 - {1'b0, f};
        p0 = 41'(a) * 41'(w);
        p1 = 41'(b) * 41'(f);
        return bts_pkg::SUM_W'(p0 + p1);
    endfunction

    // Round half up and drop 24 fraction bits
    function automatic logic [bts_pkg::RES_W-1:0] round_q16(input logic [bts_pkg::SUM_W-1:0] s);
        logic [bts_pkg::SUM_W-1:0] t;
        t = s + 40'h80_0000;
        return t[39:24];
    endfunction

    logic [bts_pkg::ROW_W-1:0]  r_top [3];
    logic [bts_pkg::ROW_W-1:0]  r_bot [3];
    logic [bts_pkg::FRAC_W-1:0] r_fy;
    logic [bts_pkg::SUM_W-1:0]  r_sum [3];
    logic [bts_pkg::RES_W-1:0]  r_res [3];

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_row) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_top[ch] <= lerp_row(chan(i_t00, ch), chan(i_t10, ch), i_fx);
                r_bot[ch] <= lerp_row(chan(i_t01, ch), chan(i_t11, ch), i_fx);
            end
            r_fy <= i_fy;
        end
        if (i_ctl.ld_col) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_sum[ch] <= lerp_col(r_top[ch], r_bot[ch], r_fy);
            end
        end
        if (i_ctl.ld_out) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_res[ch] <= round_q16(r_sum[ch]);
            end
        end
    end

    assign o_red   = r_res[0];
    assign o_green = r_res[1];
    assign o_blue  = r_res[2];

endmodule

// File: hw/rtl/bilinear_texture_sampler_core.sv
// Throughput: one item per cycle while the output is not stalled, writes and
//   samples mixed freely; the four texel fetches come from two copies of the
//   texel store, each with two read ports, all written together.
// Reset: clears every stage valid, the output valid and sets both sizes to
//   256; the texel store is not cleared and holds garbage until written.
// ---------------------------------------------------------------------------
// Bilinear texture sampler core
// Texel store with write items, coordinate scaling, neighbor addressing,
// four-texel fetch and per-channel bilinear blend in a stallable pipeline.
// ---------------------------------------------------------------------------
module bilinear_texture_sampler_core #(
    parameter int MAX_SIDE    = 256,
    parameter int STORE_DEPTH = 65536
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input items
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [15:0] texel_index, [23:16] texel_red, [31:24] texel_green,
    // [39:32] texel_blue, [55:40] coord_u, [71:56] coord_v
    input  logic [bts_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // [0] req_type
    input  logic                               i_s_tuser,
    // Result items
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [15:0] out_red, [31:16] out_green, [47:32] out_blue
    output logic [bts_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // Configuration
    input  logic                               i_cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bts_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int SW = $clog2(MAX_SIDE + 1);   // side width
    localparam int XW = 16 + SW;                 // scaled coordinate
    localparam int RW = 2 * SW;                  // row base y*w
    localparam int PW = RW + 1;                  // full texel address
    localparam int AW = $clog2(STORE_DEPTH);     // store address

    function automatic logic [SW-1:0] side_of(input logic [bts_pkg::CFG_W-1:0] val);
        logic [31:0] v;
        v = 32'(val);
        if (v == 32'd0) begin
            v = 32'd1;
        end else if (v > 32'(MAX_SIDE)) begin
            v = 32'(MAX_SIDE);
        end
        return v[SW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [SW-1:0] r_w;
    logic [SW-1:0] r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= side_of(bts_pkg::CFG_RESET_SIDE);
            r_h <= side_of(bts_pkg::CFG_RESET_SIDE);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bts_pkg::CFG_TEX_WIDTH: begin
                    r_w <= side_of(i_cfg_data);
                end
                bts_pkg::CFG_TEX_HEIGHT: begin
                    r_h <= side_of(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    logic                   r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_out_valid;
    logic                   r_smp1, r_smp2, r_smp3;
    logic [15:0]            r_idx1, r_idx2, r_idx3;
    bts_pkg::t_texel        r_tex1, r_tex2, r_tex3;
    logic [XW-1:0]          r_xs1, r_ys1;
    logic [SW-1:0]          r_x0_2, r_x1_2;
    logic [RW-1:0]          r_row0_2, r_row1_2;
    logic [15:0]            r_fx2, r_fy2, r_fx3, r_fy3, r_fx4, r_fy4;
    logic [AW-1:0]          r_a3 [4];    // 00, 10, 01, 11
    logic [3:0]             r_oob3, r_oob4;
    bts_pkg::t_texel        r_q4 [4];

    // Each stage loads when empty or when the next one takes its item.
    // A write leaves after stage 3, so it never waits on later stages.
    logic f1, f2, f3, f4, f5, f6, out_ld;

    assign out_ld = !r_out_valid || i_m_tready;
    assign f6     = !r_v6 || out_ld;
    assign f5     = !r_v5 || f6;
    assign f4     = !r_v4 || f5;
    assign f3     = !r_v3 || !r_smp3 || f4;
    assign f2     = !r_v2 || f3;
    assign f1     = !r_v1 || f2;

    assign o_s_tready = f1;

    // Input unpack
    logic [15:0]     in_idx, in_u, in_v;
    bts_pkg::t_texel in_tex;

    assign in_idx       = i_s_tdata[15:0];
    assign in_tex.red   = i_s_tdata[23:16];
    assign in_tex.green = i_s_tdata[31:24];
    assign in_tex.blue  = i_s_tdata[39:32];
    assign in_u         = i_s_tdata[55:40];
    assign in_v         = i_s_tdata[71:56];

    // Stage 2 logic: integer parts, edge clamp, row bases
    logic [SW-1:0] wm1, hm1, x0, y0, n_x0, n_y0, n_x1, n_y1;
    logic [RW-1:0] n_row0, n_row1;

    always_comb begin
        wm1    = r_w - SW'(1);
        hm1    = r_h - SW'(1);
        x0     = r_xs1[XW-1:16];
        y0     = r_ys1[XW-1:16];
        n_x0   = (x0 > wm1) ? wm1 : x0;
        n_y0   = (y0 > hm1) ? hm1 : y0;
        n_x1   = (n_x0 < wm1) ? SW'(n_x0 + SW'(1)) : wm1;
        n_y1   = (n_y0 < hm1) ? SW'(n_y0 + SW'(1)) : hm1;
        n_row0 = RW'(n_y0) * RW'(r_w);
        n_row1 = RW'(n_y1) * RW'(r_w);
    end

    // Stage 3 logic: texel addresses and range flags
    logic [PW-1:0] n_a [4];
    logic [3:0]    n_oob;

    always_comb begin
        n_a[0] = PW'(r_row0_2) + PW'(r_x0_2);
        n_a[1] = PW'(r_row0_2) + PW'(r_x1_2);
        n_a[2] = PW'(r_row1_2) + PW'(r_x0_2);
        n_a[3] = PW'(r_row1_2) + PW'(r_x1_2);
        for (int k = 0; k < 4; k++) begin
            n_oob[k] = 64'(n_a[k]) >= 64'(STORE_DEPTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_v6        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (f1) begin
                r_v1 <= i_s_tvalid;
            end
            if (f2) begin
                r_v2 <= r_v1;
            end
            if (f3) begin
                r_v3 <= r_v2;
            end
            if (f4) begin
                r_v4 <= r_v3 && r_smp3;
            end
            if (f5) begin
                r_v5 <= r_v4;
            end
            if (f6) begin
                r_v6 <= r_v5;
            end
            if (out_ld) begin
                r_out_valid <= r_v6;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (f1) begin
            r_smp1 <= (i_s_tuser == bts_pkg::REQ_SAMPLE);
            r_idx1 <= in_idx;
            r_tex1 <= in_tex;
            r_xs1  <= XW'(in_u) * XW'(r_w);
            r_ys1  <= XW'(in_v) * XW'(r_h);
        end
        if (f2) begin
            r_smp2   <= r_smp1;
            r_idx2   <= r_idx1;
            r_tex2   <= r_tex1;
            r_x0_2   <= n_x0;
            r_x1_2   <= n_x1;
            r_row0_2 <= n_row0;
            r_row1_2 <= n_row1;
            r_fx2    <= r_xs1[15:0];
            r_fy2    <= r_ys1[15:0];
        end
        if (f3) begin
            r_smp3 <= r_smp2;
            r_idx3 <= r_idx2;
            r_tex3 <= r_tex2;
            for (int k = 0; k < 4; k++) begin
                r_a3[k] <= AW'(n_a[k]);
            end
            r_oob3 <= n_oob;
            r_fx3  <= r_fx2;
            r_fy3  <= r_fy2;
        end
        if (f4) begin
            r_oob4 <= r_oob3;
            r_fx4  <= r_fx3;
            r_fy4  <= r_fy3;
        end
    end

    // ------------------------------------------------------------------
    // Texel store: two copies, two read ports each
    // ------------------------------------------------------------------
    bts_pkg::t_texel r_mem_a [STORE_DEPTH];
    bts_pkg::t_texel r_mem_b [STORE_DEPTH];
    logic            mem_we;
    logic [AW-1:0]   mem_wa;

    // A write in stage 3 always leaves this cycle, after all older samples read
    assign mem_we = r_v3 && !r_smp3 && (32'(r_idx3) < 32'(STORE_DEPTH));
    assign mem_wa = AW'(r_idx3);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_a[mem_wa] <= r_tex3;
            r_mem_b[mem_wa] <= r_tex3;
        end
        if (f4) begin
            r_q4[0] <= r_mem_a[r_a3[0]];
            r_q4[1] <= r_mem_a[r_a3[1]];
            r_q4[2] <= r_mem_b[r_a3[2]];
            r_q4[3] <= r_mem_b[r_a3[3]];
        end
    end

    // Addresses beyond the store read as zero
    bts_pkg::t_texel tx [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            tx[k] = r_oob4[k] ? '0 : r_q4[k];
        end
    end

    // ------------------------------------------------------------------
    // Blend
    // ------------------------------------------------------------------
    bts_pkg::t_blend_ctl       blend_ctl;
    logic [bts_pkg::RES_W-1:0] res_red, res_green, res_blue;

    assign blend_ctl.ld_row = f5;
    assign blend_ctl.ld_col = f6;
    assign blend_ctl.ld_out = out_ld;

    bts_blend u_blend (
        .i_clk   (i_clk),
        .i_ctl   (blend_ctl),
        .i_t00   (tx[0]),
        .i_t10   (tx[1]),
        .i_t01   (tx[2]),
        .i_t11   (tx[3]),
        .i_fx    (r_fx4),
        .i_fy    (r_fy4),
        .o_red   (res_red),
        .o_green (res_green),
        .o_blue  (res_blue)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {res_blue, res_green, res_red};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_w != '0) && (r_h != '0) && (32'(r_w) <= MAX_SIDE) && (32'(r_h) <= MAX_SIDE))
        else $error("texture size outside 1..MAX_SIDE");

    a_only_samples_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v4) |-> $past(r_v3 && r_smp3))
        else $error("fetch stage filled by a non-sample item");

    a_hold_last_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v6 && r_out_valid && !i_m_tready) |=> r_v6)
        else $error("last stage dropped an item under stall");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_smp3 && r_v4 && r_v5 && r_v6 && r_out_valid
         && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while pipeline is full and stalled");

endmodule

// File: verif/tb_top.sv
// ---------------------------------------------------------------------------
// Bilinear texture sampler testbench
// Loads texels through write items and checks every sample against a
// bilinear blend computed in the bench. Texture sizes, including zero and
// oversized register values, change between idle phases. Sender and
// receiver idle at random. A long receiver hold-off and a sender pause
// that waits for all results are included.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int STALL_LIMIT   = 3000;
    localparam int PHASE_ITEMS   = 135;
    localparam int RANDOM_PHASES = 8;
    localparam int SETTLE_CYCLES = 12;
    localparam int PRINT_CAP     = 100;

    typedef struct {
        logic        req;
        logic [15:0] index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] u;
        logic [15:0] v;
        bit          drain;   // hold until every pending result is back
    } t_tex_req;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_pixel;

    typedef enum {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_SPARSE} t_ready_mode;

    logic                          i_clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          o_s_tready;
    // [15:0] texel_index, [23:16] texel_red, [31:24] texel_green,
    // [39:32] texel_blue, [55:40] coord_u, [71:56] coord_v
    logic [bts_pkg::S_TDATA_W-1:0] s_tdata = '0;
    // [0] req_type
    logic                          s_tuser = 1'b0;
    logic                          o_m_tvalid;
    logic                          m_tready = 1'b0;
    // [15:0] out_red, [31:16] out_green, [47:32] out_blue
    logic [bts_pkg::M_TDATA_W-1:0] o_m_tdata;
    logic                          cfg_we = 1'b0;
    logic [bts_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [bts_pkg::CFG_W-1:0]     cfg_data = '0;

    t_tex_req pending_items[$];
    t_pixel   expected_pixels[$];

    // Bench copy of the texel store and size registers
    bts_pkg::t_texel texel_mem [65536];
    logic [8:0]      width_reg;
    logic [8:0]      height_reg;

    // Generator view: which texels have been scheduled for writing
    bit         texel_planned [65536];
    logic [8:0] gen_width  = bts_pkg::CFG_RESET_SIDE;
    logic [8:0] gen_height = bts_pkg::CFG_RESET_SIDE;

    int error_count      = 0;
    int writes_queued    = 0;
    int samples_queued   = 0;
    int writes_accepted  = 0;
    int samples_accepted = 0;
    int results_checked  = 0;
    int size_settings    = 1;
    int holdoff_requests = 0;
    int holdoffs_served  = 0;
    int burst_left       = 0;
    int gap_left         = 0;
    int quiet_cycles     = 0;

    bilinear_texture_sampler_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Texture math
    // ------------------------------------------------------------------
    function automatic int unsigned side_in_use(input logic [8:0] r);
        if (r == 9'd0) begin
            return 1;
        end
        if (r > 9'd256) begin
            return 256;
        end
        return 32'(r);
    endfunction

    // Four neighbor addresses (top-left, top-right, bottom-left, bottom-right)
    function automatic void locate_texels(input logic [15:0] u, input logic [15:0] v,
                                          input logic [8:0] w_reg, input logic [8:0] h_reg,
                                          output logic [3:0][15:0] addr,
                                          output logic [15:0] fx, output logic [15:0] fy);
        int unsigned w, h, x0, y0, x1, y1;
        logic [31:0] xs, ys;
        w  = side_in_use(w_reg);
        h  = side_in_use(h_reg);
        xs = 32'(u) * w;
        ys = 32'(v) * h;
        x0 = xs >> 16;
        y0 = ys >> 16;
        fx = xs[15:0];
        fy = ys[15:0];
        if (x0 > w - 1) begin
            x0 = w - 1;
        end
        if (y0 > h - 1) begin
            y0 = h - 1;
        end
        // clamp the far neighbor to the last column and row
        x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
        y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
        addr[0] = 16'(y0 * w + x0);
        addr[1] = 16'(y0 * w + x1);
        addr[2] = 16'(y1 * w + x0);
        addr[3] = 16'(y1 * w + x1);
    endfunction

    function automatic logic [15:0] blend_channel(input logic [7:0] c00, input logic [7:0] c10,
                                                  input logic [7:0] c01, input logic [7:0] c11,
                                                  input logic [15:0] fx, input logic [15:0] fy);
        logic [63:0] wx, wy, top, bot, sum;
        wx  = 64'd65536 - 64'(fx);
        wy  = 64'd65536 - 64'(fy);
        top = 64'(c00) * wx + 64'(c10) * 64'(fx);
        bot = 64'(c01) * wx + 64'(c11) * 64'(fx);
        sum = top * wy + bot * 64'(fy);
        // round half up from Q8.32 down to Q0.16 of texel/256
        sum = (sum + (64'd1 << 23)) >> 24;
        return sum[15:0];
    endfunction

    function automatic t_pixel sample_texture(input logic [15:0] u, input logic [15:0] v);
        logic [3:0][15:0] a;
        logic [15:0]      fx, fy;
        bts_pkg::t_texel  t00, t10, t01, t11;
        t_pixel           p;
        locate_texels(u, v, width_reg, height_reg, a, fx, fy);
        t00 = texel_mem[a[0]];
        t10 = texel_mem[a[1]];
        t01 = texel_mem[a[2]];
        t11 = texel_mem[a[3]];
        p.red   = blend_channel(t00.red,   t10.red,   t01.red,   t11.red,   fx, fy);
        p.green = blend_channel(t00.green, t10.green, t01.green, t11.green, fx, fy);
        p.blue  = blend_channel(t00.blue,  t10.blue,  t01.blue,  t11.blue,  fx, fy);
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Item generation
    // ------------------------------------------------------------------
    task automatic add_write(input logic [15:0] idx, input logic [23:0] rgb);
        t_tex_req    r;
        logic [31:0] rnd;
        rnd     = $urandom;
        r.req   = bts_pkg::REQ_WRITE;
        r.index = idx;
        r.red   = rgb[23:16];
        r.green = rgb[15:8];
        r.blue  = rgb[7:0];
        r.u     = rnd[15:0];
        r.v     = rnd[31:16];
        r.drain = 1'b0;
        pending_items.push_back(r);
        texel_planned[idx] = 1'b1;
        writes_queued++;
    endtask

    // Write any neighbor not yet loaded, then queue the sample
    task automatic add_sample(input logic [15:0] u, input logic [15:0] v, input bit drain);
        logic [3:0][15:0] a;
        logic [15:0]      fx, fy;
        logic [31:0]      rnd;
        t_tex_req         r;
        locate_texels(u, v, gen_width, gen_height, a, fx, fy);
        for (int i = 0; i < 4; i++) begin
            if (!texel_planned[a[i]]) begin
                rnd = $urandom;
                add_write(a[i], rnd[23:0]);
            end
        end
        rnd     = $urandom;
        r.req   = bts_pkg::REQ_SAMPLE;
        r.index = rnd[15:0];
        r.red   = rnd[23:16];
        r.green = rnd[31:24];
        rnd     = $urandom;
        r.blue  = rnd[7:0];
        r.u     = u;
        r.v     = v;
        r.drain = drain;
        pending_items.push_back(r);
        samples_queued++;
    endtask

    task automatic wait_until_idle();
        do begin
            @(negedge i_clk);
        end while (pending_items.size() != 0 || expected_pixels.size() != 0 || s_tvalid);
    endtask

    task automatic write_register(input logic [bts_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [8:0] value);
        wait_until_idle();
        // let any write still in the pipeline retire
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == bts_pkg::CFG_TEX_WIDTH) begin
            gen_width = value;
        end else begin
            gen_height = value;
        end
    endtask

    task automatic set_sizes(input logic [8:0] w, input logic [8:0] h);
        write_register(bts_pkg::CFG_TEX_WIDTH, w);
        write_register(bts_pkg::CFG_TEX_HEIGHT, h);
        size_settings++;
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] rnd;
        logic [15:0] u, v;
        logic [8:0]  w, h;
        int          start;

        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // reset sizes: corners, half and near-full weights, edge clamps
        add_write(16'h0000, 24'h000000);
        add_write(16'h0001, 24'hFFFFFF);
        add_write(16'h0100, 24'hFF00FF);
        add_write(16'h0101, 24'h00FF00);
        add_write(16'hFFFF, 24'hFFFFFF);
        add_sample(16'h0000, 16'h0000, 1'b0);
        add_sample(16'h0080, 16'h0080, 1'b0);
        add_sample(16'h00FF, 16'h00FF, 1'b0);
        add_sample(16'hFFFF, 16'hFFFF, 1'b0);
        add_sample(16'hFFFF, 16'h0000, 1'b0);
        add_sample(16'h0000, 16'hFFFF, 1'b0);

        // one-texel texture: every neighbor collapses onto texel 0
        set_sizes(9'd1, 9'd1);
        add_write(16'h0000, 24'hA5C35A);
        add_sample(16'h0000, 16'h0000, 1'b0);
        add_sample(16'hFFFF, 16'hFFFF, 1'b0);
        add_sample(16'h8001, 16'h7FFF, 1'b0);

        // zero sizes read as one
        set_sizes(9'd0, 9'd0);
        add_sample(16'hC000, 16'h4000, 1'b0);
        add_sample(16'hFFFF, 16'h0001, 1'b0);

        // oversized registers read as the maximum side
        set_sizes(9'd511, 9'd300);
        add_sample(16'hFFFF, 16'h8000, 1'b0);
        add_sample(16'h7FFF, 16'hFFFF, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin w = 9'd4;   h = 9'd4;   end
                1: begin w = 9'd256; h = 9'd256; end
                2: begin w = 9'd1;   h = 9'd256; end
                3: begin w = 9'd256; h = 9'd1;   end
                4: begin w = 9'd0;   h = 9'd511; end
                5: begin w = 9'd17;  h = 9'd9;   end
                default: begin
                    w = 9'($urandom_range(1, 64));
                    h = 9'($urandom_range(1, 64));
                end
            endcase
            set_sizes(w, h);
            if (p == 0 || p == 5) begin
                holdoff_requests++;
            end
            start = writes_queued + samples_queued;
            while (writes_queued + samples_queued - start < PHASE_ITEMS) begin
                rnd = $urandom;
                if ($urandom_range(0, 99) < 25) begin
                    add_write(rnd[15:0], rnd[31:8]);
                end else begin
                    case ($urandom_range(0, 5))
                        0: begin
                            u = 16'($urandom_range(0, 255));
                            v = 16'($urandom_range(16'hFF00, 16'hFFFF));
                        end
                        1: begin
                            u = 16'($urandom_range(16'hFF00, 16'hFFFF));
                            v = 16'($urandom_range(0, 255));
                        end
                        default: begin
                            u = rnd[15:0];
                            v = rnd[31:16];
                        end
                    endcase
                    add_sample(u, v, (start + 40 == writes_queued + samples_queued) ||
                                     ($urandom_range(0, 99) == 0));
                end
            end
        end

        wait_until_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d texel writes and %0d samples over %0d texture size settings,",
                 writes_accepted, samples_accepted, size_settings);
        $display("including zero and oversized sizes; %0d results compared, %0d long hold-offs.",
                 results_checked, holdoffs_served);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender: bursts of items with random gaps
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_items
        t_tex_req head;
        bit       offer;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || o_s_tready) begin
            offer = 1'b0;
            if (s_tvalid) begin
                void'(pending_items.pop_front());
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
            end else if (pending_items.size() != 0) begin
                head = pending_items[0];
                // a draining item waits for the pipeline to empty out
                if (!(head.drain && (s_tvalid || expected_pixels.size() != 0))) begin
                    offer = 1'b1;
                end
            end
            s_tvalid <= offer;
            if (offer) begin
                s_tdata <= {head.v, head.u, head.blue, head.green, head.red, head.index};
                s_tuser <= head.req;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall patterns plus requested long hold-offs
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_ready
        t_ready_mode mode;
        int          mode_left;
        int          holdoff_left;
        if (!rst_n) begin
            m_tready     <= 1'b0;
            mode         = READY_ALWAYS;
            mode_left    = 0;
            holdoff_left = 0;
        end else if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
            m_tready <= 1'b0;
        end else if (holdoffs_served != holdoff_requests) begin
            holdoffs_served++;
            holdoff_left = $urandom_range(60, 100);
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode      = t_ready_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 150);
            end else begin
                mode_left = mode_left - 1;
            end
            case (mode)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
                READY_MOSTLY: m_tready <= ($urandom_range(0, 9) != 0);
                READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:      m_tready <= 1'b1;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Prediction on accepted items and configuration writes
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : track_config
        if (!rst_n) begin
            width_reg  = bts_pkg::CFG_RESET_SIDE;
            height_reg = bts_pkg::CFG_RESET_SIDE;
        end else if (cfg_we) begin
            case (cfg_idx)
                bts_pkg::CFG_TEX_WIDTH:  width_reg  = cfg_data;
                bts_pkg::CFG_TEX_HEIGHT: height_reg = cfg_data;
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin : predict_items
        if (rst_n && s_tvalid && o_s_tready) begin
            if (s_tuser == bts_pkg::REQ_WRITE) begin
                texel_mem[s_tdata[15:0]] = '{red: s_tdata[23:16], green: s_tdata[31:24],
                                             blue: s_tdata[39:32]};
                writes_accepted++;
            end else begin
                expected_pixels.push_back(sample_texture(s_tdata[55:40], s_tdata[71:56]));
                samples_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_pixel want;
        if (rst_n && o_m_tvalid && m_tready) begin
            results_checked++;
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result, tdata %h", o_m_tdata));
            end else begin
                want = expected_pixels.pop_front();
                if (o_m_tdata[15:0] !== want.red) begin
                    report_mismatch($sformatf("result %0d red %h, want %h",
                                              results_checked, o_m_tdata[15:0], want.red));
                end
                if (o_m_tdata[31:16] !== want.green) begin
                    report_mismatch($sformatf("result %0d green %h, want %h",
                                              results_checked, o_m_tdata[31:16], want.green));
                end
                if (o_m_tdata[47:32] !== want.blue) begin
                    report_mismatch($sformatf("result %0d blue %h, want %h",
                                              results_checked, o_m_tdata[47:32], want.blue));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no item moves for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watchdog
        if (!rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_pixels.size());
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// File: bilinear_texture_sampler_core.f
hw/rtl/bts_pkg.sv
hw/rtl/bts_blend.sv
hw/rtl/bilinear_texture_sampler_core.sv
verif/tb_top.sv
